// ===== rtl/trc_pkg.sv =====
// Shared types, codes and match patterns for the tagged response capture block.
// Used by trc_framer and tagged_response_capture_core; depends on nothing.
package trc_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_ARM  = 1'b1;

  localparam logic [POS_W-1:0] HDR_LAST = 3'd4;
  localparam logic [POS_W-1:0] TRL_LAST = 3'd5;

  localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SEEK    = 2'd1,
    PH_CAPTURE = 2'd2
  } phase_t;

  typedef struct packed {
    logic              capture_valid;
    logic [IDX_W-1:0]  capture_index;
    logic [BYTE_W-1:0] capture_byte;
    logic              finished;
    phase_t            phase;
  } result_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b | CASE_BIT;
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] hdr_char(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h2b;  // '+'
      3'd1:    c = 8'h69;  // 'i'
      3'd2:    c = 8'h70;  // 'p'
      3'd3:    c = 8'h64;  // 'd'
      3'd4:    c = 8'h2c;  // ','
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] trl_char(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h0d;
      3'd1:    c = 8'h0a;
      3'd2:    c = 8'h6f;  // 'o'
      3'd3:    c = 8'h6b;  // 'k'
      3'd4:    c = 8'h0d;
      3'd5:    c = 8'h0a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/trc_framer.sv =====
// Framer state (phase, match position, capture count, finished flag) and the
// combinational next-state and result logic for one request. Uses trc_pkg.
module trc_framer #(
  parameter int CAPTURE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       kind,
  input  logic [trc_pkg::BYTE_W-1:0] rx_byte,
  output trc_pkg::result_t           res
);

  localparam int CntW = $clog2(CAPTURE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(CAPTURE_DEPTH);

  trc_pkg::phase_t                phase, phase_next;
  logic [trc_pkg::POS_W-1:0]      match_pos, match_pos_next;
  logic [CntW-1:0]                count, count_next;
  logic                           done_flag, done_flag_next;
  logic [trc_pkg::BYTE_W-1:0]     ch;
  logic [CntW+trc_pkg::IDX_W-1:0] count_ext;

  assign ch        = trc_pkg::fold_case(rx_byte);
  assign count_ext = {{trc_pkg::IDX_W{1'b0}}, count};

  always_comb begin
    phase_next     = phase;
    match_pos_next = match_pos;
    count_next     = count;
    done_flag_next = done_flag;
    res            = '0;
    if (kind == trc_pkg::KIND_ARM) begin
      phase_next     = trc_pkg::PH_SEEK;
      match_pos_next = '0;
      count_next     = '0;
      done_flag_next = 1'b0;
    end else begin
      res.capture_byte = ch;
      case (phase)
        trc_pkg::PH_SEEK: begin
          if (ch == trc_pkg::hdr_char(match_pos)) begin
            if (match_pos == trc_pkg::HDR_LAST) begin
              phase_next     = trc_pkg::PH_CAPTURE;
              match_pos_next = '0;
            end else begin
              match_pos_next = match_pos + 3'd1;
            end
          end else begin
            match_pos_next = '0;
          end
        end
        trc_pkg::PH_CAPTURE: begin
          if (count < DepthC) begin
            res.capture_valid = 1'b1;
            res.capture_index = count_ext[trc_pkg::IDX_W-1:0];
            count_next        = count + CntW'(1);
          end
          if (ch == trc_pkg::trl_char(match_pos)) begin
            if (match_pos == trc_pkg::TRL_LAST) begin
              phase_next     = trc_pkg::PH_IDLE;
              match_pos_next = '0;
              done_flag_next = 1'b1;
            end else begin
              match_pos_next = match_pos + 3'd1;
            end
          end else begin
            match_pos_next = '0;
          end
        end
        default: begin
        end
      endcase
    end
    res.finished = done_flag_next;
    res.phase    = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= trc_pkg::PH_IDLE;
      match_pos <= '0;
      count     <= '0;
      done_flag <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      match_pos <= match_pos_next;
      count     <= count_next;
      done_flag <= done_flag_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_capture_only_in_capture: assert property (@(posedge clk) disable iff (rst)
    res.capture_valid |-> phase == trc_pkg::PH_CAPTURE)
    else $error("capture outside capture phase");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= DepthC)
    else $error("capture count past depth");

  a_finish_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && !done_flag && done_flag_next |=> phase == trc_pkg::PH_IDLE && done_flag)
    else $error("trailer match did not idle the framer");

  a_seek_pos_range: assert property (@(posedge clk) disable iff (rst)
    phase == trc_pkg::PH_SEEK |-> match_pos <= trc_pkg::HDR_LAST)
    else $error("header match position out of range");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(count) && $stable(match_pos))
    else $error("framer state moved without a request");
`endif

endmodule

// ===== rtl/tagged_response_capture_core.sv =====
// Receive-side framer: input register, framer logic and result register.
// Takes one request per cycle while out_stall does not hold the result
// register; state advances as a request moves from the input register into the
// result register, so throughput is set only by out_stall. Depends on trc_pkg
// and trc_framer.
module tagged_response_capture_core #(
  parameter int CAPTURE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [trc_pkg::BYTE_W-1:0]  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        capture_valid,
  output logic [trc_pkg::IDX_W-1:0]   capture_index,
  output logic [trc_pkg::BYTE_W-1:0]  capture_byte,
  output logic                        finished,
  output logic [1:0]                  phase_now
);

  logic                       s1_valid;
  logic                       s1_kind;
  logic [trc_pkg::BYTE_W-1:0] s1_byte;
  logic                       out_ready;
  logic                       step;
  trc_pkg::result_t           res;
  trc_pkg::result_t           out_res;

  assign out_ready = !out_valid || !out_stall;
  assign step      = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  trc_framer #(
    .CAPTURE_DEPTH(CAPTURE_DEPTH)
  ) u_framer (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .kind   (s1_kind),
    .rx_byte(s1_byte),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= step;
      end
    end
    if (in_valid && !in_stall) begin
      s1_kind <= kind;
      s1_byte <= rx_byte;
    end
    if (step) begin
      out_res <= res;
    end
  end

  assign capture_valid = out_res.capture_valid;
  assign capture_index = out_res.capture_index;
  assign capture_byte  = out_res.capture_byte;
  assign finished      = out_res.finished;
  assign phase_now     = out_res.phase;

endmodule
